// ----- src/wsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared result type and header constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam logic [7:0] FIN_BIT_MASK = 8'h80;
    localparam logic [7:0] OPCODE_MASK  = 8'h0f;
    localparam logic [7:0] LEN_MASK     = 8'h7f;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [3:0] EXT16_BYTES  = 4'd2;
    localparam logic [3:0] EXT64_BYTES  = 4'd8;
    localparam logic [3:0] MASK_BYTES   = 4'd4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic [63:0] payload_length;
        logic [31:0] mask_key;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

endpackage

// ----- src/wsd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Holds the frame state and works out the state update and the result for
// one registered byte.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic [7:0] i_byte,
    output logic    o_res_valid,
    output t_result o_res
);

    typedef enum logic [2:0] {
        PH_BYTE0   = 3'd0,
        PH_BYTE1   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [3:0]  r_count,     n_count;
    logic        r_fin,       n_fin;
    logic [3:0]  r_opcode,    n_opcode;
    logic [6:0]  r_short,     n_short;
    logic [63:0] r_length,    n_length;
    logic [31:0] r_mask,      n_mask;
    logic [63:0] r_remaining, n_remaining;

    logic [3:0]  count_inc;
    logic [3:0]  ext_need;
    logic [63:0] rem_dec;
    logic [7:0]  len_byte;
    logic [7:0]  op_byte;

    assign count_inc = r_count + 4'd1;
    assign ext_need  = (r_short == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
    assign rem_dec   = r_remaining - 64'd1;
    assign len_byte  = i_byte & LEN_MASK;
    assign op_byte   = i_byte & OPCODE_MASK;

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_short     = r_short;
        n_length    = r_length;
        n_mask      = r_mask;
        n_remaining = r_remaining;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_phase)
            PH_BYTE1: begin
                n_short = len_byte[6:0];
                n_count = '0;
                n_mask  = '0;
                if (len_byte[6:0] == LEN_EXT16 || len_byte[6:0] == LEN_EXT64) begin
                    n_length = '0;
                    n_phase  = PH_EXTLEN;
                end else begin
                    n_length = {57'd0, len_byte[6:0]};
                    n_phase  = PH_MASK;
                end
            end
            PH_EXTLEN: begin
                n_length = {r_length[55:0], i_byte};
                n_count  = count_inc;
                if (count_inc >= ext_need) begin
                    n_count = '0;
                    n_phase = PH_MASK;
                end
            end
            PH_MASK: begin
                n_mask  = {r_mask[23:0], i_byte};
                n_count = count_inc;
                if (count_inc >= MASK_BYTES) begin
                    n_count     = '0;
                    n_remaining = r_length;
                    o_res_valid = 1'b1;
                    o_res.kind           = KIND_HEADER;
                    o_res.fin_flag       = r_fin;
                    o_res.frame_opcode   = r_opcode;
                    o_res.payload_length = r_length;
                    o_res.mask_key       = {r_mask[23:0], i_byte};
                    o_res.data_byte      = '0;
                    o_res.last           = (r_length == 64'd0);
                    n_phase = (r_length == 64'd0) ? PH_BYTE0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_remaining = rem_dec;
                o_res_valid = 1'b1;
                o_res.kind           = KIND_PAYLOAD;
                o_res.fin_flag       = r_fin;
                o_res.frame_opcode   = r_opcode;
                o_res.payload_length = r_length;
                o_res.mask_key       = r_mask;
                o_res.data_byte      = i_byte;
                o_res.last           = (rem_dec == 64'd0);
                if (rem_dec == 64'd0) begin
                    n_phase = PH_BYTE0;
                end
            end
            default: begin
                // Unused phase codes behave like the wait for byte 0.
                n_fin       = ((i_byte & FIN_BIT_MASK) == FIN_BIT_MASK);
                n_opcode    = op_byte[3:0];
                n_short     = '0;
                n_length    = '0;
                n_mask      = '0;
                n_remaining = '0;
                n_count     = '0;
                n_phase     = PH_BYTE1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BYTE0;
            r_count     <= '0;
            r_fin       <= 1'b0;
            r_opcode    <= '0;
            r_short     <= '0;
            r_length    <= '0;
            r_mask      <= '0;
            r_remaining <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_short     <= n_short;
            r_length    <= n_length;
            r_mask      <= n_mask;
            r_remaining <= n_remaining;
        end
    end

endmodule

// ----- src/wsd_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsd_out_reg
    import wsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // The register can take a new result when empty or when it is being emptied.
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- src/websocket_frame_deframer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received byte stream into WebSocket frame headers and raw payload.
// ----------------------------------------------------------------------------
// Each byte is taken into an input register, parsed and, if it completes a
// header or is a payload byte, written to a result register, which drives the
// outputs. One byte is accepted per clock while the result side keeps up.
// Header results carry FIN, opcode, the full decoded length and the mask key;
// payload bytes are passed through as received, without unmasking, with the
// last byte of each frame flagged. Stall on the result side reaches the input
// stall in the same cycle once both the input register and the result
// register are full.
module websocket_frame_deframer_core
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic        o_fin_flag,
    output logic [3:0]  o_frame_opcode,
    output logic [63:0] o_payload_length,
    output logic [31:0] o_mask_key,
    output logic [7:0]  o_data_byte,
    output logic        o_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_ready;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign step       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_fin_flag       = out_res.fin_flag;
    assign o_frame_opcode   = out_res.frame_opcode;
    assign o_payload_length = out_res.payload_length;
    assign o_mask_key       = out_res.mask_key;
    assign o_data_byte      = out_res.data_byte;
    assign o_last           = out_res.last;

endmodule
